FILE: src/spx_pkg.sv
// ============================================================================
// spx_pkg: shared types and constants of the segment/polyline intersector
// Holds the configuration record, the controller-to-datapath command and
// status records, register indexes and fixed-point widths.
// ============================================================================
`default_nettype none

package spx_pkg;

    // Fixed-point widths
    localparam int COORD_W  = 32;              // Q16.16 coordinate
    localparam int OPND_W   = COORD_W + 2;     // multiplier operand
    localparam int PROD_W   = 2 * OPND_W;      // multiplier product
    localparam int AREA_W   = PROD_W + 2;      // double area, with headroom
    localparam int QUO_W    = COORD_W + 1;     // |t| magnitude, 33 bits
    localparam int T_W      = QUO_W + 1;       // signed t
    localparam int IDX_W    = 16;              // edge index width
    localparam int DIV_STEPS = COORD_W;        // quotient bits after the top bit
    localparam int MAX_EDGES_DEF = 65536;

    // Register map, byte address is 4 * index
    localparam int CFG_ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_SEG_START_X = 3'd0,
        REG_SEG_START_Y = 3'd1,
        REG_SEG_END_X   = 3'd2,
        REG_SEG_END_Y   = 3'd3,
        REG_SINGLE_SEL  = 3'd4,
        REG_TOLERANCE   = 3'd5
    } reg_idx_t;

    localparam logic [31:0] TOL_RESET = 32'd429497;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      single_sel;
        logic [31:0]               tol;
    } cfg_t;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        MUL_HOLD,
        MUL_ABC0,
        MUL_ABC1,
        MUL_ABD0,
        MUL_ABD1,
        MUL_CDA0,
        MUL_CDA1,
        MUL_OFFX,
        MUL_OFFY
    } mul_op_t;

    // What to do with the registered product
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_ABC_SET,
        ACC_ABC_SUB,
        ACC_ABD_SET,
        ACC_ABD_SUB,
        ACC_CDA_SET,
        ACC_CDA_SUB,
        ACC_PX,
        ACC_PY
    } acc_op_t;

    typedef struct packed {
        logic    load;      // latch edge vertices
        mul_op_t mul;
        acc_op_t acc;
        logic    prep;      // form denominator, cdb and |cda|
        logic    decide;    // form |den| and the sign of t
        logic    div_init;  // first quotient bit or saturation
        logic    div_step;  // one restoring division step
        logic    sign;      // apply sign to quotient
    } dp_cmd_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } dp_stat_t;

    // a - b, widened to the multiplier operand width
    function automatic logic signed [OPND_W-1:0] sdiff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [OPND_W-1:0] wa;
        logic signed [OPND_W-1:0] wb;
        wa = {{(OPND_W-COORD_W){a[COORD_W-1]}}, a};
        wb = {{(OPND_W-COORD_W){b[COORD_W-1]}}, b};
        return wa - wb;
    endfunction

endpackage

`default_nettype wire

FILE: src/spx_regs.sv
// ============================================================================
// spx_regs: configuration register file
// APB-style write/read port holding the reference segment, mode and
// shared-endpoint tolerance.
// ============================================================================
`default_nettype none

module spx_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [spx_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    output spx_pkg::cfg_t                           cfg
);

    spx_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Write a register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sx         <= '0;
            cfg_reg.sy         <= '0;
            cfg_reg.ex         <= '0;
            cfg_reg.ey         <= '0;
            cfg_reg.single_sel <= 1'b1;
            cfg_reg.tol        <= spx_pkg::TOL_RESET;
        end else if (wr_en) begin
            case (idx)
                spx_pkg::REG_SEG_START_X: cfg_reg.sx         <= pwdata;
                spx_pkg::REG_SEG_START_Y: cfg_reg.sy         <= pwdata;
                spx_pkg::REG_SEG_END_X:   cfg_reg.ex         <= pwdata;
                spx_pkg::REG_SEG_END_Y:   cfg_reg.ey         <= pwdata;
                spx_pkg::REG_SINGLE_SEL:  cfg_reg.single_sel <= pwdata[0];
                spx_pkg::REG_TOLERANCE:   cfg_reg.tol        <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (idx)
            spx_pkg::REG_SEG_START_X: prdata = cfg_reg.sx;
            spx_pkg::REG_SEG_START_Y: prdata = cfg_reg.sy;
            spx_pkg::REG_SEG_END_X:   prdata = cfg_reg.ex;
            spx_pkg::REG_SEG_END_Y:   prdata = cfg_reg.ey;
            spx_pkg::REG_SINGLE_SEL:  prdata = {31'd0, cfg_reg.single_sel};
            spx_pkg::REG_TOLERANCE:   prdata = cfg_reg.tol;
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/spx_dp.sv
// ============================================================================
// spx_dp: area, division and offset datapath
// One shared 34x34 multiplier forms the double areas and offsets; a
// restoring divider yields t one quotient bit per cycle.
// ============================================================================
`default_nettype none

module spx_dp (
    input  wire logic                                   aclk,
    input  wire spx_pkg::cfg_t                          cfg,
    input  wire spx_pkg::dp_cmd_t                       cmd,
    input  wire logic signed [spx_pkg::COORD_W-1:0]     in_cx,
    input  wire logic signed [spx_pkg::COORD_W-1:0]     in_cy,
    input  wire logic signed [spx_pkg::COORD_W-1:0]     in_dx,
    input  wire logic signed [spx_pkg::COORD_W-1:0]     in_dy,
    output spx_pkg::dp_stat_t                           stat
);

    localparam int CW = spx_pkg::COORD_W;
    localparam int OW = spx_pkg::OPND_W;
    localparam int PW = spx_pkg::PROD_W;
    localparam int AW = spx_pkg::AREA_W;
    localparam int QW = spx_pkg::QUO_W;
    localparam int TW = spx_pkg::T_W;
    localparam int SW = PW - CW + 1;   // offset plus start coordinate

    logic signed [CW-1:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] abc_reg, abd_reg, cda_reg, den_reg, cdb_reg;
    logic        [AW-1:0] nabs_reg, dabs_reg, rem_reg;
    logic        [QW-1:0] quo_reg;
    logic                 sat_reg, neg_reg;
    logic signed [TW-1:0] t_reg;
    logic signed [CW-1:0] px_reg, py_reg;

    logic signed [OW-1:0] opa, opb;
    logic signed [AW-1:0] prod_ext;
    logic signed [SW-1:0] pt_sum_x, pt_sum_y;
    logic        [AW:0]   rem_dbl, d_dbl;
    logic                 side1, side2, cda_big;

    // Operand selection for the shared multiplier
    always_comb begin
        case (cmd.mul)
            spx_pkg::MUL_ABC0: begin
                opa = spx_pkg::sdiff(cfg.sx, cx_reg);
                opb = spx_pkg::sdiff(cfg.ey, cy_reg);
            end
            spx_pkg::MUL_ABC1: begin
                opa = spx_pkg::sdiff(cfg.sy, cy_reg);
                opb = spx_pkg::sdiff(cfg.ex, cx_reg);
            end
            spx_pkg::MUL_ABD0: begin
                opa = spx_pkg::sdiff(cfg.sx, dx_reg);
                opb = spx_pkg::sdiff(cfg.ey, dy_reg);
            end
            spx_pkg::MUL_ABD1: begin
                opa = spx_pkg::sdiff(cfg.sy, dy_reg);
                opb = spx_pkg::sdiff(cfg.ex, dx_reg);
            end
            spx_pkg::MUL_CDA0: begin
                opa = spx_pkg::sdiff(cx_reg, cfg.sx);
                opb = spx_pkg::sdiff(dy_reg, cfg.sy);
            end
            spx_pkg::MUL_CDA1: begin
                opa = spx_pkg::sdiff(cy_reg, cfg.sy);
                opb = spx_pkg::sdiff(dx_reg, cfg.sx);
            end
            spx_pkg::MUL_OFFX: begin
                opa = t_reg;
                opb = spx_pkg::sdiff(cfg.ex, cfg.sx);
            end
            spx_pkg::MUL_OFFY: begin
                opa = t_reg;
                opb = spx_pkg::sdiff(cfg.ey, cfg.sy);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_ext = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};

    // Start coordinate plus floor(t * span / 2^32)
    assign pt_sum_x = {{(SW-CW){cfg.sx[CW-1]}}, cfg.sx}
                    + {prod_reg[PW-1], prod_reg[PW-1:CW]};
    assign pt_sum_y = {{(SW-CW){cfg.sy[CW-1]}}, cfg.sy}
                    + {prod_reg[PW-1], prod_reg[PW-1:CW]};

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi)      return hi[CW-1:0];
        else if (v < lo) return lo[CW-1:0];
        else             return v[CW-1:0];
    endfunction

    assign rem_dbl = {rem_reg, 1'b0};
    assign d_dbl   = {dabs_reg, 1'b0};

    // Side tests
    assign side1   = (abc_reg[AW-1] && !abd_reg[AW-1] && abd_reg != '0)
                  || (abd_reg[AW-1] && !abc_reg[AW-1] && abc_reg != '0);
    assign side2   = (cda_reg[AW-1] && !cdb_reg[AW-1] && cdb_reg != '0)
                  || (cdb_reg[AW-1] && !cda_reg[AW-1] && cda_reg != '0);
    assign cda_big = nabs_reg > {{(AW-32){1'b0}}, cfg.tol};

    assign stat.hit = side1 && (!cda_big || side2);
    assign stat.px  = px_reg;
    assign stat.py  = py_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= in_cx;
            cy_reg <= in_cy;
            dx_reg <= in_dx;
            dy_reg <= in_dy;
        end

        // Register each product
        if (cmd.mul != spx_pkg::MUL_HOLD) begin
            prod_reg <= opa * opb;
        end

        // Accumulate areas or finish a point
        case (cmd.acc)
            spx_pkg::ACC_ABC_SET: abc_reg <= prod_ext;
            spx_pkg::ACC_ABC_SUB: abc_reg <= abc_reg - prod_ext;
            spx_pkg::ACC_ABD_SET: abd_reg <= prod_ext;
            spx_pkg::ACC_ABD_SUB: abd_reg <= abd_reg - prod_ext;
            spx_pkg::ACC_CDA_SET: cda_reg <= prod_ext;
            spx_pkg::ACC_CDA_SUB: cda_reg <= cda_reg - prod_ext;
            spx_pkg::ACC_PX:      px_reg  <= sat_coord(pt_sum_x);
            spx_pkg::ACC_PY:      py_reg  <= sat_coord(pt_sum_y);
            default: ;
        endcase

        if (cmd.prep) begin
            den_reg  <= abd_reg - abc_reg;
            cdb_reg  <= cda_reg + abc_reg - abd_reg;
            nabs_reg <= cda_reg[AW-1] ? -cda_reg : cda_reg;
        end

        if (cmd.decide) begin
            dabs_reg <= den_reg[AW-1] ? -den_reg : den_reg;
            neg_reg  <= (cda_reg[AW-1] && !den_reg[AW-1] && den_reg != '0)
                     || (den_reg[AW-1] && !cda_reg[AW-1] && cda_reg != '0);
        end

        // Top quotient bit, or saturate when |cda| >= 2|den|
        if (cmd.div_init) begin
            if ({1'b0, nabs_reg} >= d_dbl) begin
                sat_reg <= 1'b1;
                quo_reg <= '1;
                rem_reg <= nabs_reg;
            end else if (nabs_reg >= dabs_reg) begin
                sat_reg <= 1'b0;
                quo_reg <= {{(QW-1){1'b0}}, 1'b1};
                rem_reg <= nabs_reg - dabs_reg;
            end else begin
                sat_reg <= 1'b0;
                quo_reg <= '0;
                rem_reg <= nabs_reg;
            end
        end

        // Restoring step
        if (cmd.div_step && !sat_reg) begin
            if (rem_dbl >= {1'b0, dabs_reg}) begin
                rem_reg <= AW'(rem_dbl - {1'b0, dabs_reg});
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_dbl[AW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end

        if (cmd.sign) begin
            t_reg <= neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        end
    end

endmodule

`default_nettype wire

FILE: src/spx_ctrl.sv
// ============================================================================
// spx_ctrl: sequencing controller
// Steps the datapath through areas, side tests, division and offsets,
// keeps the hit bookkeeping and drives the result register.
// ============================================================================
`default_nettype none

module spx_ctrl #(
    parameter int MAX_EDGES = spx_pkg::MAX_EDGES_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_restart,
    output logic                                        in_ready,
    input  wire logic                                   single_sel,
    input  wire spx_pkg::dp_stat_t                      stat,
    output spx_pkg::dp_cmd_t                            cmd,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        out_tested,
    output logic                                        out_hit,
    output logic signed [spx_pkg::COORD_W-1:0]          out_px,
    output logic signed [spx_pkg::COORD_W-1:0]          out_py,
    output logic                                        out_first_found,
    output logic [spx_pkg::IDX_W-1:0]                   out_first_edge,
    output logic                                        out_second_found,
    output logic [spx_pkg::IDX_W-1:0]                   out_second_edge
);

    localparam int IW = spx_pkg::IDX_W;
    localparam int CAP_INT = (MAX_EDGES - 1) < 65535 ? (MAX_EDGES - 1) : 65535;
    localparam logic [IW-1:0] EDGE_CAP = IW'(CAP_INT);
    localparam logic [2:0] AREA_LAST = 3'd6;
    localparam logic [1:0] OFS_LAST  = 2'd2;
    localparam logic [4:0] DIV_LAST  = 5'(spx_pkg::DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_PREP,
        ST_DECIDE,
        ST_DINIT,
        ST_DIV,
        ST_SIGN,
        ST_OFS,
        ST_FINISH
    } state_t;

    state_t          state_reg;
    logic [4:0]      step_reg;
    logic            tested_reg, hit_reg;
    logic            found_reg, second_reg;
    logic [IW-1:0]   first_idx_reg, second_idx_reg, seen_reg;
    logic [1:0]      hits_reg;
    logic            out_valid_reg;
    logic            accept, deliver;
    logic            found_now;
    logic [1:0]      hits_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign deliver   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign found_now = found_reg && !in_restart;
    assign hits_next = (hits_reg < 2'd3) ? hits_reg + 2'd1 : hits_reg;
    assign out_valid = out_valid_reg;

    // Commands per state
    always_comb begin
        cmd = '0;
        cmd.mul = spx_pkg::MUL_HOLD;
        cmd.acc = spx_pkg::ACC_NONE;
        case (state_reg)
            ST_IDLE: cmd.load = accept;
            ST_AREA: begin
                case (step_reg[2:0])
                    3'd0: cmd.mul = spx_pkg::MUL_ABC0;
                    3'd1: begin
                        cmd.mul = spx_pkg::MUL_ABC1;
                        cmd.acc = spx_pkg::ACC_ABC_SET;
                    end
                    3'd2: begin
                        cmd.mul = spx_pkg::MUL_ABD0;
                        cmd.acc = spx_pkg::ACC_ABC_SUB;
                    end
                    3'd3: begin
                        cmd.mul = spx_pkg::MUL_ABD1;
                        cmd.acc = spx_pkg::ACC_ABD_SET;
                    end
                    3'd4: begin
                        cmd.mul = spx_pkg::MUL_CDA0;
                        cmd.acc = spx_pkg::ACC_ABD_SUB;
                    end
                    3'd5: begin
                        cmd.mul = spx_pkg::MUL_CDA1;
                        cmd.acc = spx_pkg::ACC_CDA_SET;
                    end
                    default: cmd.acc = spx_pkg::ACC_CDA_SUB;
                endcase
            end
            ST_PREP:   cmd.prep = 1'b1;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_DINIT:  cmd.div_init = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_SIGN:   cmd.sign = 1'b1;
            ST_OFS: begin
                case (step_reg[1:0])
                    2'd0: cmd.mul = spx_pkg::MUL_OFFX;
                    2'd1: begin
                        cmd.mul = spx_pkg::MUL_OFFY;
                        cmd.acc = spx_pkg::ACC_PX;
                    end
                    default: cmd.acc = spx_pkg::ACC_PY;
                endcase
            end
            default: ;
        endcase
    end

    // State, bookkeeping and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            tested_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            found_reg      <= 1'b0;
            second_reg     <= 1'b0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            seen_reg       <= '0;
            hits_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && !deliver) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (in_restart) begin
                            found_reg      <= 1'b0;
                            second_reg     <= 1'b0;
                            first_idx_reg  <= '0;
                            second_idx_reg <= '0;
                            seen_reg       <= '0;
                            hits_reg       <= '0;
                        end
                        hit_reg  <= 1'b0;
                        step_reg <= '0;
                        if (!found_now || !single_sel) begin
                            tested_reg <= 1'b1;
                            state_reg  <= ST_AREA;
                        end else begin
                            tested_reg <= 1'b0;
                            state_reg  <= ST_FINISH;
                        end
                    end
                end
                ST_AREA: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg[2:0] == AREA_LAST) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: state_reg <= ST_DECIDE;
                ST_DECIDE: begin
                    hit_reg   <= stat.hit;
                    state_reg <= stat.hit ? ST_DINIT : ST_FINISH;
                end
                ST_DINIT: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == DIV_LAST) begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    step_reg  <= '0;
                    state_reg <= ST_OFS;
                end
                ST_OFS: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg[1:0] == OFS_LAST) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (deliver) begin
                        out_valid_reg    <= 1'b1;
                        out_tested       <= tested_reg;
                        out_hit          <= hit_reg;
                        out_px           <= hit_reg ? stat.px : '0;
                        out_py           <= hit_reg ? stat.py : '0;
                        out_first_found  <= found_reg | hit_reg;
                        out_first_edge   <= (hit_reg && !found_reg) ? seen_reg : first_idx_reg;
                        out_second_found <= second_reg
                                         | (hit_reg && !single_sel && hits_next == 2'd2);
                        out_second_edge  <= (hit_reg && !single_sel && hits_next == 2'd2
                                             && !second_reg) ? seen_reg : second_idx_reg;
                        // Update kept state for a tested edge
                        if (tested_reg) begin
                            if (seen_reg < EDGE_CAP) begin
                                seen_reg <= seen_reg + IW'(1);
                            end
                            if (hit_reg && !found_reg) begin
                                found_reg     <= 1'b1;
                                first_idx_reg <= seen_reg;
                            end
                            if (hit_reg && !single_sel) begin
                                hits_reg <= hits_next;
                                if (hits_next == 2'd2 && !second_reg) begin
                                    second_reg     <= 1'b1;
                                    second_idx_reg <= seen_reg;
                                end
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/segment_polyline_intersector.sv
// ============================================================================
// segment_polyline_intersector: reference segment vs polyline edge test
// Tests each edge for a crossing with the configured segment and reports the
// crossing point and the first and second hitting edges.
// ============================================================================
//
//  Channel  Direction  Handshake           Carries
//  s_       in         s_tvalid/s_tready   one polyline edge, restart flag
//  m_       out        m_tvalid/m_tready   one result per edge
//  apb      in/out     psel/penable/pready configuration registers
//
//  An edge without a hit passes through the area, prep and decide states
//  to finish; a hit adds the restoring divider for t, sign and offsets.
//  An edge not tested (single-select mode after a hit) goes from idle
//  straight to finish.
//  One edge is in work at a time; the result register lets the next edge
//  enter while a result waits for m_tready.
//  aresetn is synchronous, active low, and clears all control state.
// ============================================================================
`default_nettype none

module segment_polyline_intersector #(
    parameter int MAX_EDGES = spx_pkg::MAX_EDGES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // tdata: edge_from_x, edge_from_y, edge_to_x, edge_to_y
    input  wire logic [127:0]                       s_tdata,
    // tuser: restart
    input  wire logic                               s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: point_x, point_y, first_found, first_edge, second_found,
    //        second_edge, zero pad
    output logic [103:0]                            m_tdata,
    // tuser: tested, hit
    output logic [1:0]                              m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [spx_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    spx_pkg::cfg_t      cfg;
    spx_pkg::dp_cmd_t   cmd;
    spx_pkg::dp_stat_t  stat;

    logic                                   o_tested, o_hit, o_ff, o_sf;
    logic signed [spx_pkg::COORD_W-1:0]     o_px, o_py;
    logic [spx_pkg::IDX_W-1:0]              o_fe, o_se;

    spx_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spx_dp u_dp (
        .aclk  (aclk),
        .cfg   (cfg),
        .cmd   (cmd),
        .in_cx (s_tdata[31:0]),
        .in_cy (s_tdata[63:32]),
        .in_dx (s_tdata[95:64]),
        .in_dy (s_tdata[127:96]),
        .stat  (stat)
    );

    spx_ctrl #(
        .MAX_EDGES (MAX_EDGES)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_restart       (s_tuser),
        .in_ready         (s_tready),
        .single_sel       (cfg.single_sel),
        .stat             (stat),
        .cmd              (cmd),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_tested       (o_tested),
        .out_hit          (o_hit),
        .out_px           (o_px),
        .out_py           (o_py),
        .out_first_found  (o_ff),
        .out_first_edge   (o_fe),
        .out_second_found (o_sf),
        .out_second_edge  (o_se)
    );

    // Pack the result
    assign m_tuser = {o_hit, o_tested};
    assign m_tdata = {6'd0, o_se, o_sf, o_fe, o_ff, o_py, o_px};

endmodule

`default_nettype wire

FILE: src/spx_checker.sv
// ============================================================================
// spx_port_props: port-level checks for the intersector
// Watches the result channel for stalls and consistency of reported hits.
// ============================================================================
`default_nettype none

module spx_port_props (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [103:0]   m_tdata,
    input  wire logic [1:0]     m_tuser,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A hit comes only from a tested edge
    a_hit_tested: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("hit on untested edge");

    // No hit leaves the point at zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[63:0] == 64'd0)
        else $error("point set without hit");

    // A second crossing needs a first one
    a_second_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[81] |-> m_tdata[64])
        else $error("second found without first");

    // The first index reads zero until found
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[64] |-> m_tdata[80:65] == 16'd0)
        else $error("first index without first hit");

endmodule

bind segment_polyline_intersector spx_port_props u_spx_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
